@@ design/assert_macros.svh @@
// Assertion macros shared by the checked ALU RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

@@ design/csalu_pkg.sv @@
// Package for the checked signed ALU: operation codes and width defaults.
// Depends on nothing.
package csalu_pkg;
    localparam int DataWidthDefault = 32;
    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;
endpackage

@@ design/csalu_cell.sv @@
// One restoring-division cell of the checked ALU pipeline.
// Depends on csalu_pkg.
module csalu_cell
    import csalu_pkg::*;
#(
    parameter int DATA_WIDTH = DataWidthDefault,
    parameter int BIT_IDX = 0
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  valid_in,
    input  logic [DATA_WIDTH:0]   rem_in,
    input  logic [DATA_WIDTH-1:0] quo_in,
    input  logic [DATA_WIDTH-1:0] dvd_in,
    input  logic [DATA_WIDTH-1:0] dvs_in,
    input  logic                  pass_in,
    input  logic [DATA_WIDTH-1:0] val_in,
    input  logic                  err_in,
    input  logic                  neg_in,
    output logic                  valid_out,
    output logic [DATA_WIDTH:0]   rem_out,
    output logic [DATA_WIDTH-1:0] quo_out,
    output logic [DATA_WIDTH-1:0] dvd_out,
    output logic [DATA_WIDTH-1:0] dvs_out,
    output logic                  pass_out,
    output logic [DATA_WIDTH-1:0] val_out,
    output logic                  err_out,
    output logic                  neg_out
);
    logic [DATA_WIDTH:0] shifted;
    logic [DATA_WIDTH+1:0] trial;
    logic valid_reg;
    logic [DATA_WIDTH:0] rem_reg;
    logic [DATA_WIDTH-1:0] quo_reg, dvd_reg, dvs_reg, val_reg;
    logic pass_reg, err_reg, neg_reg;

    always_comb
    begin
        shifted = {rem_in[DATA_WIDTH-1:0], dvd_in[BIT_IDX]};
        trial   = {1'b0, shifted} - {2'b00, dvs_in};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    // Advance the partial remainder by one quotient bit.
    always_ff @(posedge clk)
    begin
        if (trial[DATA_WIDTH+1])
        begin
            rem_reg <= shifted;
            quo_reg <= quo_in;
        end
        else
        begin
            rem_reg <= trial[DATA_WIDTH:0];
            quo_reg <= quo_in | (DATA_WIDTH'(1) << BIT_IDX);
        end
        dvd_reg  <= dvd_in;
        dvs_reg  <= dvs_in;
        pass_reg <= pass_in;
        val_reg  <= val_in;
        err_reg  <= err_in;
        neg_reg  <= neg_in;
    end

    assign valid_out = valid_reg;
    assign rem_out   = rem_reg;
    assign quo_out   = quo_reg;
    assign dvd_out   = dvd_reg;
    assign dvs_out   = dvs_reg;
    assign pass_out  = pass_reg;
    assign val_out   = val_reg;
    assign err_out   = err_reg;
    assign neg_out   = neg_reg;
endmodule

@@ design/checked_signed_alu.sv @@
// Top level of the checked signed ALU: front stage, cell chain, result stage.
// Depends on csalu_pkg, csalu_cell and assert_macros.svh.
//
// channel | ports                           | handshake
// --------+---------------------------------+-------------------------------
// command | op, operand_a, operand_b        | start high while busy low
// result  | value, error_flag               | done high for one cycle
//
// One transaction is accepted every cycle; busy is held low always.
// The pipeline has one front stage (add, subtract,
// multiply and divide set-up), one cell per quotient bit, one result stage.
// Add, subtract and multiply results ride through the chain untouched.
// Reset clears only the valid bits; the receiver cannot stall, so done
// follows start through the front stage, the cells and the result stage.
`include "assert_macros.svh"
module checked_signed_alu
    import csalu_pkg::*;
#(
    parameter int DATA_WIDTH = DataWidthDefault
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   op,
    input  logic signed [DATA_WIDTH-1:0] operand_a,
    input  logic signed [DATA_WIDTH-1:0] operand_b,
    output logic                         done,
    output logic signed [DATA_WIDTH-1:0] value,
    output logic                         error_flag
);
    localparam int W = DATA_WIDTH;

    logic accept;
    logic sa, sb;
    logic [W-1:0] ma, mb, sum, diff;
    logic [2*W-1:0] prod;
    logic [W:0] limit;
    logic [W-1:0] front_val;
    logic front_err, front_pass;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        sa    = operand_a[W-1];
        sb    = operand_b[W-1];
        ma    = sa ? W'(-operand_a) : operand_a;
        mb    = sb ? W'(-operand_b) : operand_b;
        sum   = operand_a + operand_b;
        diff  = operand_a - operand_b;
        prod  = {{W{1'b0}}, ma} * {{W{1'b0}}, mb};
        limit = (sa ^ sb) ? ((W+1)'(1) << (W-1)) : (((W+1)'(1) << (W-1)) - (W+1)'(1));
        front_val  = '0;
        front_err  = 1'b0;
        front_pass = 1'b1;
        case (op_t'(op))
            OP_ADD:
            begin
                front_err = (sa == sb) && (sum[W-1] != sa);
                front_val = sum;
            end
            OP_SUB:
            begin
                front_err = (sa != sb) && (diff[W-1] != sa);
                front_val = diff;
            end
            OP_MUL:
            begin
                front_err = (prod > {{(W-1){1'b0}}, limit});
                front_val = (sa ^ sb) ? W'(-prod[W-1:0]) : prod[W-1:0];
            end
            default:
            begin
                front_pass = 1'b0;
                front_err  = (mb == '0);
            end
        endcase
        if (front_err)
        begin
            front_val = '0;
        end
    end

    // Front stage register: hand the operands to the chain.
    logic valid_reg;
    logic [W-1:0] dvd_reg, dvs_reg, val_reg;
    logic pass_reg, err_reg, neg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg  <= ma;
        dvs_reg  <= mb;
        val_reg  <= front_val;
        pass_reg <= front_pass;
        err_reg  <= front_err;
        neg_reg  <= sa ^ sb;
    end

    // Chain of cells, most significant quotient bit first.
    logic           c_valid [W+1];
    logic [W:0]     c_rem   [W+1];
    logic [W-1:0]   c_quo   [W+1];
    logic [W-1:0]   c_dvd   [W+1];
    logic [W-1:0]   c_dvs   [W+1];
    logic           c_pass  [W+1];
    logic [W-1:0]   c_val   [W+1];
    logic           c_err   [W+1];
    logic           c_neg   [W+1];

    assign c_valid[0] = valid_reg;
    assign c_rem[0]   = '0;
    assign c_quo[0]   = '0;
    assign c_dvd[0]   = dvd_reg;
    assign c_dvs[0]   = dvs_reg;
    assign c_pass[0]  = pass_reg;
    assign c_val[0]   = val_reg;
    assign c_err[0]   = err_reg;
    assign c_neg[0]   = neg_reg;

    for (genvar i = 0; i < W; i++)
    begin : g_cell
        csalu_cell #(
            .DATA_WIDTH(W),
            .BIT_IDX   (W-1-i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .valid_in (c_valid[i]),
            .rem_in   (c_rem[i]),
            .quo_in   (c_quo[i]),
            .dvd_in   (c_dvd[i]),
            .dvs_in   (c_dvs[i]),
            .pass_in  (c_pass[i]),
            .val_in   (c_val[i]),
            .err_in   (c_err[i]),
            .neg_in   (c_neg[i]),
            .valid_out(c_valid[i+1]),
            .rem_out  (c_rem[i+1]),
            .quo_out  (c_quo[i+1]),
            .dvd_out  (c_dvd[i+1]),
            .dvs_out  (c_dvs[i+1]),
            .pass_out (c_pass[i+1]),
            .val_out  (c_val[i+1]),
            .err_out  (c_err[i+1]),
            .neg_out  (c_neg[i+1])
        );
    end

    // Result stage: range check and sign of the quotient.
    logic [W-1:0] quo;
    logic [W-1:0] top;
    logic div_ovf, fin_err;
    logic [W-1:0] fin_val;
    logic done_reg, err_out_reg;
    logic [W-1:0] value_reg;

    always_comb
    begin
        quo     = c_quo[W];
        top     = W'(1) << (W-1);
        div_ovf = c_neg[W] ? (quo > top) : (quo >= top);
        if (c_pass[W])
        begin
            fin_err = c_err[W];
            fin_val = c_val[W];
        end
        else
        begin
            fin_err = c_err[W] || div_ovf;
            fin_val = fin_err ? '0 : (c_neg[W] ? W'(-quo) : quo);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= c_valid[W];
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg   <= fin_val;
        err_out_reg <= fin_err;
    end

    assign done       = done_reg;
    assign value      = value_reg;
    assign error_flag = err_out_reg;

    `ASSERT_IMPLIES(a_err_zero, clk, rst_n, done && error_flag, value == '0)
    `ASSERT_NEXT(a_front_valid, clk, rst_n, accept, valid_reg)
    `ASSERT_NEXT(a_chain_done, clk, rst_n, c_valid[W], done)
    `ASSERT_IMPLIES(a_never_busy, clk, rst_n, 1'b1, !busy)
endmodule
